/* rtl/hstm_pkg.sv */
// ----------------------------------------------------------------------------
// hstm_pkg : static header table constants and chain token type
// Holds the 61 static table rows (name and value strings and lengths) and
// the token that travels down the row of compare cells.
// ----------------------------------------------------------------------------
`default_nettype none

package hstm_pkg;

    localparam int ENTRY_COUNT   = 61;
    localparam int NAME_BYTES    = 32;
    localparam int VALUE_BYTES   = 16;
    localparam int NPOS_W        = $clog2(NAME_BYTES);
    localparam int VPOS_W        = $clog2(VALUE_BYTES);
    localparam int INDEX_W       = 6;

    localparam logic [NPOS_W-1:0] NAME_POS_MAX  = NPOS_W'(NAME_BYTES - 1);
    localparam logic [VPOS_W-1:0] VALUE_POS_MAX = VPOS_W'(VALUE_BYTES - 1);

    // command codes carried in the first tuser bit
    localparam logic CMD_NAME_ONLY  = 1'b0;
    localparam logic CMD_NAME_VALUE = 1'b1;

    typedef logic [8*NAME_BYTES-1:0]  t_name_str;
    typedef logic [8*VALUE_BYTES-1:0] t_value_str;

    // strings are right-justified; the cells left-justify them by length
    localparam t_name_str NAME_STR [ENTRY_COUNT] = '{
        ":authority", ":method", ":method", ":path", ":path",
        ":scheme", ":scheme", ":status", ":status", ":status",
        ":status", ":status", ":status", ":status", "accept-charset",
        "accept-encoding", "accept-language", "accept-ranges", "accept",
        "access-control-allow-origin", "age", "allow", "authorization",
        "cache-control", "content-disposition", "content-encoding",
        "content-language", "content-length", "content-location",
        "content-range", "content-type", "cookie", "date", "etag", "expect",
        "expires", "from", "host", "if-match", "if-modified-since",
        "if-none-match", "if-range", "if-unmodified-since", "last-modified",
        "link", "location", "max-forwards", "proxy-authenticate",
        "proxy-authorization", "range", "referer", "refresh", "retry-after",
        "server", "set-cookie", "strict-transport-security",
        "transfer-encoding", "user-agent", "vary", "via", "www-authenticate"
    };

    localparam logic [NPOS_W-1:0] ROW_NAME_SIZE [ENTRY_COUNT] = '{
        5'd10, 5'd7,  5'd7,  5'd5,  5'd5,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,
        5'd7,  5'd7,  5'd7,  5'd7,  5'd14, 5'd15, 5'd15, 5'd13, 5'd6,  5'd27,
        5'd3,  5'd5,  5'd13, 5'd13, 5'd19, 5'd16, 5'd16, 5'd14, 5'd16, 5'd13,
        5'd12, 5'd6,  5'd4,  5'd4,  5'd6,  5'd7,  5'd4,  5'd4,  5'd8,  5'd17,
        5'd13, 5'd8,  5'd19, 5'd13, 5'd4,  5'd8,  5'd12, 5'd18, 5'd19, 5'd5,
        5'd7,  5'd7,  5'd11, 5'd6,  5'd10, 5'd25, 5'd17, 5'd10, 5'd4,  5'd3,
        5'd16
    };

    localparam t_value_str VALUE_STR [ENTRY_COUNT] = '{
        1: "GET", 2: "POST", 3: "/", 4: "/index.html", 5: "http", 6: "https",
        7: "200", 8: "204", 9: "206", 10: "304", 11: "400", 12: "404",
        13: "500", 15: "gzip, deflate", default: '0
    };

    localparam logic [VPOS_W-1:0] ROW_VALUE_SIZE [ENTRY_COUNT] = '{
        1: 4'd3, 2: 4'd4, 3: 4'd1, 4: 4'd11, 5: 4'd4, 6: 4'd5,
        7: 4'd3, 8: 4'd3, 9: 4'd3, 10: 4'd3, 11: 4'd3, 12: 4'd3, 13: 4'd3,
        15: 4'd13, default: 4'd0
    };

    // one octet moving down the cell row, with its positions and the
    // partial lookup result gathered so far
    typedef struct packed {
        logic               valid;
        logic               last;
        logic               cmd;
        logic               value_part;
        logic [7:0]         data;
        logic [NPOS_W-1:0]  cmp_pos;
        logic [NPOS_W-1:0]  fin_npos;
        logic [VPOS_W-1:0]  fin_vpos;
        logic               found;
        logic [INDEX_W-1:0] index;
    } t_token;

endpackage

`default_nettype wire

/* rtl/hstm_cell.sv */
// ----------------------------------------------------------------------------
// hstm_cell : compare cell for one static table row
// Keeps the name and value match bits of one row, updates them when a token
// passes and, on a last token, folds this row into the running result.
// ----------------------------------------------------------------------------
`default_nettype none

module hstm_cell #(
    parameter int P_ENTRY = 0
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_adv,
    input  hstm_pkg::t_token     i_tok,
    output hstm_pkg::t_token     o_tok
);
    import hstm_pkg::*;

    localparam logic [NPOS_W-1:0]  NLEN = ROW_NAME_SIZE[P_ENTRY];
    localparam logic [VPOS_W-1:0]  VLEN = ROW_VALUE_SIZE[P_ENTRY];
    localparam t_name_str  NM = NAME_STR[P_ENTRY]  << (8 * (NAME_BYTES  - int'(NLEN)));
    localparam t_value_str VL = VALUE_STR[P_ENTRY] << (8 * (VALUE_BYTES - int'(VLEN)));
    localparam logic [INDEX_W-1:0] MY_INDEX = INDEX_W'(P_ENTRY + 1);

    logic               r_nm;
    logic               r_vm;
    logic               n_nm;
    logic               n_vm;
    t_token             r_tok;
    logic               r_tok_valid;
    t_token             n_tok;
    logic [VPOS_W-1:0]  vpos;
    logic [7:0]         nm_char;
    logic [7:0]         vl_char;
    logic               hit;
    logic               row_ok;

    // select the stored octet at the token position (inverted pos = reverse index)
    assign vpos    = i_tok.cmp_pos[VPOS_W-1:0];
    assign nm_char = NM[{~i_tok.cmp_pos, 3'b000} +: 8];
    assign vl_char = VL[{~vpos, 3'b000} +: 8];

    always_comb begin
        if (i_tok.value_part) begin
            hit = (vpos < VLEN) && (vl_char == i_tok.data);
        end else begin
            hit = (i_tok.cmp_pos < NLEN) && (nm_char == i_tok.data);
        end
    end

    // match bits after this octet
    always_comb begin
        n_nm = r_nm;
        n_vm = r_vm;
        if (i_tok.value_part) begin
            n_vm = r_vm & hit;
        end else begin
            n_nm = r_nm & hit;
        end
    end

    // full row check at the end of the field
    always_comb begin
        row_ok = n_nm && (i_tok.fin_npos == NLEN);
        if (i_tok.cmd == CMD_NAME_VALUE) begin
            row_ok = row_ok && n_vm && (i_tok.fin_vpos == VLEN);
        end
    end

    // token handed to the next cell
    always_comb begin
        n_tok = i_tok;
        if (i_tok.last && !i_tok.found && row_ok) begin
            n_tok.found = 1'b1;
            n_tok.index = MY_INDEX;
        end
    end

    // match state, back to all ones after a last token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nm <= 1'b1;
            r_vm <= 1'b1;
        end else if (i_adv && i_tok.valid) begin
            if (i_tok.last) begin
                r_nm <= 1'b1;
                r_vm <= 1'b1;
            end else begin
                r_nm <= n_nm;
                r_vm <= n_vm;
            end
        end
    end

    // token stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else if (i_adv) begin
            r_tok_valid <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    always_comb begin
        o_tok       = r_tok;
        o_tok.valid = r_tok_valid;
    end

endmodule

`default_nettype wire

/* rtl/hpack_static_table_match.sv */
// Path of a result: the last octet enters the first of 61 compare cells at its
// accepting edge, then passes 60 more cell stages and the output register,
// which then offers the result transfer.
// Throughput: one octet per cycle; the row of cells advances as a whole and
// stalls only when a result reaches its end while the output register is full
// and not being read.
// Reset: synchronous active-low i_rst_n empties the cell row and output register,
// clears both position counters and sets every match bit.
// ----------------------------------------------------------------------------
// hpack_static_table_match : static header table lookup
// Octets of a header name and value stream in; the index of the matching
// static table row (or zero) streams out after the octet marked tlast.
// ----------------------------------------------------------------------------
`default_nettype none

module hpack_static_table_match (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  wire  [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  wire  [1:0] i_s_axis_tuser,   // [0] command, [1] in_value_part
    input  wire        i_s_axis_tlast,   // last_item
    output logic       o_m_axis_tvalid,
    input  wire        i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata    // [5:0] table_index, [7:6] zero
);
    import hstm_pkg::*;

    logic [NPOS_W-1:0]  r_name_pos;
    logic [VPOS_W-1:0]  r_val_pos;
    logic [NPOS_W-1:0]  name_inc;
    logic [VPOS_W-1:0]  val_inc;
    logic               adv;
    logic               accept;
    t_token             head_tok;
    t_token             chain [ENTRY_COUNT+1];
    t_token             end_tok;
    logic               r_out_valid;
    logic [INDEX_W-1:0] r_out_index;

    // stall only when a result reaches the end and cannot be stored
    assign end_tok         = chain[ENTRY_COUNT];
    assign adv             = !(end_tok.valid && end_tok.last && r_out_valid
                               && !i_m_axis_tready);
    assign o_s_axis_tready = adv;
    assign accept          = i_s_axis_tvalid && adv;

    // saturating position increments
    assign name_inc = (r_name_pos == NAME_POS_MAX) ? r_name_pos : r_name_pos + 1'b1;
    assign val_inc  = (r_val_pos == VALUE_POS_MAX) ? r_val_pos : r_val_pos + 1'b1;

    // token entering the first cell
    always_comb begin
        head_tok.valid      = i_s_axis_tvalid;
        head_tok.last       = i_s_axis_tlast;
        head_tok.cmd        = i_s_axis_tuser[0];
        head_tok.value_part = i_s_axis_tuser[1];
        head_tok.data       = i_s_axis_tdata;
        head_tok.found      = 1'b0;
        head_tok.index      = '0;
        if (i_s_axis_tuser[1]) begin
            head_tok.cmp_pos  = NPOS_W'(r_val_pos);
            head_tok.fin_npos = r_name_pos;
            head_tok.fin_vpos = val_inc;
        end else begin
            head_tok.cmp_pos  = r_name_pos;
            head_tok.fin_npos = name_inc;
            head_tok.fin_vpos = r_val_pos;
        end
    end

    assign chain[0] = head_tok;

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_pos <= '0;
            r_val_pos  <= '0;
        end else if (accept) begin
            if (i_s_axis_tlast) begin
                r_name_pos <= '0;
                r_val_pos  <= '0;
            end else if (i_s_axis_tuser[1]) begin
                r_val_pos <= val_inc;
            end else begin
                r_name_pos <= name_inc;
            end
        end
    end

    // one compare cell per table row
    for (genvar g = 0; g < ENTRY_COUNT; g++) begin : g_cell
        hstm_cell #(
            .P_ENTRY (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_tok   (chain[g]),
            .o_tok   (chain[g+1])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && end_tok.valid && end_tok.last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && end_tok.valid && end_tok.last) begin
            r_out_index <= end_tok.found ? end_tok.index : '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_index};

    // a result never names a row beyond the table
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_index <= INDEX_W'(ENTRY_COUNT)))
        else $error("result index beyond table");

    // counters restart after the end of a field
    a_pos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_s_axis_tlast) |=> (r_name_pos == '0 && r_val_pos == '0))
        else $error("position counters not cleared after last octet");

    // the row stalls only while a result is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |-> (r_out_valid && end_tok.valid && end_tok.last))
        else $error("cell row stalled without a pending result");

    // a stalled end token with a result stays in place
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> (end_tok.valid && end_tok.last))
        else $error("end token lost during stall");

endmodule

`default_nettype wire

/* tb/tb_hpack_static_table_match.sv */
// ----------------------------------------------------------------------------
// tb_hpack_static_table_match : static header table lookup testbench
// Streams header name and value octets into the block, tracks the per-row
// match state alongside it and checks every returned table index in order.
// Runs three idle patterns, one long output stall and a full drain pause.
// ----------------------------------------------------------------------------
module tb_hpack_static_table_match;
    timeunit 1ns;
    timeprecision 1ps;

    import hstm_pkg::*;

    localparam logic PART_NAME  = 1'b0;
    localparam logic PART_VALUE = 1'b1;

    localparam logic [4:0] NM_POS_TOP  = 5'd31;
    localparam logic [3:0] VAL_POS_TOP = 4'd15;

    localparam int PHASE_ITEMS  = 620;
    localparam int TOTAL_ITEMS  = 1850;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int QUIET_LIMIT  = 5000;

    typedef struct packed {
        logic       vpart;
        logic [7:0] octet;
    } t_hdr_octet;

    typedef struct packed {
        logic       cmd;
        logic       vpart;
        logic [7:0] octet;
        logic       last;
    } t_octet_item;

    // static table rows, 0-based here, reported 1-based
    string row_name [ENTRY_COUNT] = '{
        ":authority", ":method", ":method", ":path", ":path",
        ":scheme", ":scheme", ":status", ":status", ":status",
        ":status", ":status", ":status", ":status", "accept-charset",
        "accept-encoding", "accept-language", "accept-ranges", "accept",
        "access-control-allow-origin", "age", "allow", "authorization",
        "cache-control", "content-disposition", "content-encoding",
        "content-language", "content-length", "content-location",
        "content-range", "content-type", "cookie", "date", "etag", "expect",
        "expires", "from", "host", "if-match", "if-modified-since",
        "if-none-match", "if-range", "if-unmodified-since", "last-modified",
        "link", "location", "max-forwards", "proxy-authenticate",
        "proxy-authorization", "range", "referer", "refresh", "retry-after",
        "server", "set-cookie", "strict-transport-security",
        "transfer-encoding", "user-agent", "vary", "via", "www-authenticate"
    };

    string row_value [ENTRY_COUNT] = '{
        "", "GET", "POST", "/", "/index.html", "http", "https", "200", "204",
        "206", "304", "400", "404", "500", "", "gzip, deflate",
        "", "", "", "", "", "", "", "", "",
        "", "", "", "", "", "", "", "", "",
        "", "", "", "", "", "", "", "", "",
        "", "", "", "", "", "", "", "", "",
        "", "", "", "", "", "", "", "", ""
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;    // [7:0] data_byte
    logic [1:0] s_tuser = '0;    // [0] command, [1] in_value_part
    logic       s_tlast = 1'b0;  // last_item
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;         // [5:0] table_index, [7:6] zero

    // lookup state tracked alongside the block
    logic [4:0]             nm_pos = '0;
    logic [3:0]             val_pos = '0;
    logic [ENTRY_COUNT-1:0] nm_alive = '1;
    logic [ENTRY_COUNT-1:0] val_alive = '1;

    t_octet_item        octet_queue [$];
    t_hdr_octet         seq_q [$];
    logic [INDEX_W-1:0] lookup_results [$];

    int items_queued  = 0;
    int errors        = 0;
    int snd_idle      = 0;
    int rcv_idle      = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    hpack_static_table_match uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // fold one accepted octet into the row match state, emit index on last
    function automatic void match_octet(input logic cmd, input logic vpart,
                                        input logic [7:0] oct, input logic last);
        logic [ENTRY_COUNT-1:0] col;
        logic [INDEX_W-1:0]     idx;
        logic                   ok;
        string                  s;
        int                     pos;
        col = '0;
        pos = vpart ? int'(val_pos) : int'(nm_pos);
        for (int i = 0; i < ENTRY_COUNT; i++) begin
            s = vpart ? row_value[i] : row_name[i];
            if (pos < s.len() && 8'(s.getc(pos)) == oct)
                col[i] = 1'b1;
        end
        if (vpart == PART_VALUE) begin
            val_alive = val_alive & col;
            if (val_pos < VAL_POS_TOP)
                val_pos = val_pos + 4'd1;
        end else begin
            nm_alive = nm_alive & col;
            if (nm_pos < NM_POS_TOP)
                nm_pos = nm_pos + 5'd1;
        end
        if (last) begin
            idx = '0;
            // scan downward so the lowest matching row wins
            for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
                ok = nm_alive[i] && int'(nm_pos) == row_name[i].len();
                if (cmd == CMD_NAME_VALUE)
                    ok = ok && val_alive[i] && int'(val_pos) == row_value[i].len();
                if (ok)
                    idx = INDEX_W'(i + 1);
            end
            lookup_results.push_back(idx);
            nm_pos = '0;
            val_pos = '0;
            nm_alive = '1;
            val_alive = '1;
        end
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic vpart);
        t_hdr_octet h;
        h.vpart = vpart;
        h.octet = b;
        seq_q.push_back(h);
    endtask

    task automatic add_str(input string s, input logic vpart);
        for (int j = 0; j < s.len(); j++)
            add_byte(8'(s.getc(j)), vpart);
    endtask

    // turn the collected octets into one lookup; only the last carries cmd
    task automatic flush_lookup(input logic cmd);
        t_octet_item it;
        if (seq_q.size() == 0)
            add_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        for (int j = 0; j < seq_q.size(); j++) begin
            it.vpart = seq_q[j].vpart;
            it.octet = seq_q[j].octet;
            it.last  = (j == seq_q.size() - 1);
            it.cmd   = it.last ? cmd : 1'($urandom_range(1));
            octet_queue.push_back(it);
        end
        items_queued += seq_q.size();
        seq_q.delete();
    endtask

    // one random lookup, mostly built around a real table row
    task automatic random_lookup();
        int    e;
        int    k;
        int    n;
        int    p;
        string nm;
        string vl;
        logic  cmd;
        e = $urandom_range(ENTRY_COUNT - 1);
        nm = row_name[e];
        vl = row_value[e];
        cmd = $urandom_range(1) ? CMD_NAME_VALUE : CMD_NAME_ONLY;
        k = $urandom_range(99);
        if (k < 45) begin
            add_str(nm, PART_NAME);
            add_str(vl, PART_VALUE);
        end else if (k < 58) begin
            // name of one row, value of another
            add_str(nm, PART_NAME);
            add_str(row_value[$urandom_range(ENTRY_COUNT - 1)], PART_VALUE);
        end else if (k < 68) begin
            // a single octet altered
            add_str(nm, PART_NAME);
            add_str(vl, PART_VALUE);
            p = $urandom_range(seq_q.size() - 1);
            if ($urandom_range(1))
                seq_q[p].octet = seq_q[p].octet ^ 8'(1 << $urandom_range(7));
            else
                seq_q[p].octet = 8'($urandom_range(255));
        end else if (k < 75) begin
            // name cut short or run on
            if ($urandom_range(1)) begin
                n = $urandom_range(nm.len() - 1);
                for (int j = 0; j < n; j++)
                    add_byte(8'(nm.getc(j)), PART_NAME);
            end else begin
                add_str(nm, PART_NAME);
                repeat ($urandom_range(1, 3))
                    add_byte(8'($urandom_range(8'h61, 8'h7a)), PART_NAME);
            end
            add_str(vl, PART_VALUE);
        end else if (k < 80) begin
            // overlong name or value, counters saturate
            add_str(nm, PART_NAME);
            if ($urandom_range(1)) begin
                repeat ($urandom_range(31 - nm.len(), 40 - nm.len()))
                    add_byte(8'($urandom_range(255)), PART_NAME);
                add_str(vl, PART_VALUE);
            end else begin
                add_str(vl, PART_VALUE);
                repeat ($urandom_range(15 - vl.len(), 20 - vl.len()))
                    add_byte(8'($urandom_range(255)), PART_VALUE);
            end
        end else if (k < 84) begin
            // value octets only, no name
            if (vl.len() > 0)
                add_str(vl, PART_VALUE);
            else
                repeat ($urandom_range(1, 5))
                    add_byte(8'($urandom_range(255)), PART_VALUE);
        end else if (k < 90) begin
            // name octets resumed after the value
            n = $urandom_range(nm.len() - 1);
            for (int j = 0; j < n; j++)
                add_byte(8'(nm.getc(j)), PART_NAME);
            add_str(vl, PART_VALUE);
            for (int j = n; j < nm.len(); j++)
                add_byte(8'(nm.getc(j)), PART_NAME);
        end else begin
            repeat ($urandom_range(1, 8))
                add_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        flush_lookup(cmd);
    endtask

    task automatic wait_idle();
        while (octet_queue.size() != 0 || s_tvalid || lookup_results.size() != 0)
            @(posedge clk);
    endtask

    // input side: track accepted octets, then offer the next one
    always @(posedge clk) begin
        t_octet_item it;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                match_octet(s_tuser[0], s_tuser[1], s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (octet_queue.size() != 0 && $urandom_range(99) >= snd_idle) begin
                    it = octet_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= it.octet;
                    s_tuser  <= {it.vpart, it.cmd};
                    s_tlast  <= it.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: compare each result transfer, then pick ready
    always @(posedge clk) begin
        logic [INDEX_W-1:0] want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (lookup_results.size() == 0) begin
                    $error("unexpected result transfer, table_index %0d", m_tdata[5:0]);
                    errors++;
                end else begin
                    want = lookup_results.pop_front();
                    if (m_tdata[INDEX_W-1:0] !== want) begin
                        $error("table_index: expected %0d, actual %0d",
                               want, m_tdata[INDEX_W-1:0]);
                        errors++;
                    end
                    if (m_tdata[7:INDEX_W] !== '0) begin
                        $error("tdata padding: expected 0, actual %0d", m_tdata[7:INDEX_W]);
                        errors++;
                    end
                end
            end
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // sender idles a little, receiver a lot
        snd_idle = 22;
        rcv_idle = 85;

        // empty value in name+value mode
        add_str("via", PART_NAME);
        flush_lookup(CMD_NAME_VALUE);
        // lone value octet, all ones, empty name
        add_byte(8'hff, PART_VALUE);
        flush_lookup(CMD_NAME_ONLY);
        // lone name octet, all zeros
        add_byte(8'h00, PART_NAME);
        flush_lookup(CMD_NAME_VALUE);
        add_str(":path", PART_NAME);
        add_str("/", PART_VALUE);
        flush_lookup(CMD_NAME_VALUE);
        // value octets ignored in name-only mode
        add_str("age", PART_NAME);
        add_str("x", PART_VALUE);
        flush_lookup(CMD_NAME_ONLY);
        // late name octet after the value
        add_str("ag", PART_NAME);
        add_str("z", PART_VALUE);
        add_byte("e", PART_NAME);
        flush_lookup(CMD_NAME_ONLY);

        while (items_queued < PHASE_ITEMS)
            random_lookup();
        wait_idle();

        // roles swapped
        snd_idle = 85;
        rcv_idle = 22;
        while (items_queued < 2 * PHASE_ITEMS)
            random_lookup();
        wait_idle();

        // no idling, with one long output stall to back the block up
        snd_idle = 0;
        rcv_idle = 0;
        hold_requests++;
        while (items_queued < TOTAL_ITEMS)
            random_lookup();
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (lookup_results.size() != 0) begin
            $error("table_index: %0d results never arrived", lookup_results.size());
            errors++;
        end
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/hstm_pkg.sv
rtl/hstm_cell.sv
rtl/hpack_static_table_match.sv
tb/tb_hpack_static_table_match.sv
